### hdl/smjp_pkg.sv
// Shared constants, codes and types of the sort-merge join probe.
package smjp_pkg;

  localparam int unsigned INNER_DEPTH = 4096;
  localparam int unsigned IDX_W       = $clog2(INNER_DEPTH);
  localparam int unsigned CNT_W       = $clog2(INNER_DEPTH + 1);
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned REF_W       = 32;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned ENTRY_W     = KEY_W + REF_W;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_PROBE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic               matched;
    logic [REF_W-1:0]   outer_ref;
    logic [REF_W-1:0]   inner_ref;
    logic               exhausted;
    logic [TOTAL_W-1:0] match_total;
  } res_t;

endpackage

### hdl/smjp_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module smjp_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/smjp_seq.sv
// Sequencer: load, start and probe handling with the cursor walk over the inner store.
module smjp_seq import smjp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [KEY_W-1:0]   key_i,
  input  logic [REF_W-1:0]   ref_i,
  output logic               we_o,
  output logic [IDX_W-1:0]   waddr_o,
  output logic [ENTRY_W-1:0] wdata_o,
  output logic [IDX_W-1:0]   raddr_o,
  input  logic [ENTRY_W-1:0] rdata_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output res_t               res_o
);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   loaded_q, loaded_d;
  logic [CNT_W-1:0]   cursor_q, cursor_d;
  logic               done_q, done_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [KEY_W-1:0]   pkey_q, pkey_d;
  logic [REF_W-1:0]   pref_q, pref_d;
  logic               hit_q, hit_d;
  logic [REF_W-1:0]   iref_q, iref_d;

  logic [CNT_W-1:0]   cursor_nxt;
  logic [KEY_W-1:0]   rkey;

  assign cursor_nxt = cursor_q + CNT_W'(1);
  assign rkey       = rdata_i[KEY_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      loaded_q <= '0;
      cursor_q <= '0;
      done_q   <= 1'b0;
      total_q  <= '0;
    end else begin
      state_q  <= state_d;
      loaded_q <= loaded_d;
      cursor_q <= cursor_d;
      done_q   <= done_d;
      total_q  <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pkey_q <= pkey_d;
    pref_q <= pref_d;
    hit_q  <= hit_d;
    iref_q <= iref_d;
  end

  always_comb begin
    state_d     = state_q;
    loaded_d    = loaded_q;
    cursor_d    = cursor_q;
    done_d      = done_q;
    total_d     = total_q;
    pkey_d      = pkey_q;
    pref_d      = pref_q;
    hit_d       = hit_q;
    iref_d      = iref_q;
    in_ready_o  = 1'b0;
    we_o        = 1'b0;
    waddr_o     = loaded_q[IDX_W-1:0];
    wdata_o     = {ref_i, key_i};
    raddr_o     = cursor_q[IDX_W-1:0];
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (action_i)
            ACT_START: begin
              loaded_d = '0;
              cursor_d = '0;
              done_d   = 1'b0;
              total_d  = '0;
            end
            ACT_LOAD: begin
              // drop loads once the store is full
              if (loaded_q != CNT_W'(INNER_DEPTH)) begin
                we_o     = 1'b1;
                loaded_d = loaded_q + CNT_W'(1);
              end
            end
            ACT_PROBE: begin
              pkey_d  = key_i;
              pref_d  = ref_i;
              state_d = ST_ISSUE;
            end
            default: ;
          endcase
        end
      end
      ST_ISSUE: begin
        hit_d  = 1'b0;
        iref_d = '0;
        if (done_q) begin
          state_d = ST_EMIT;
        end else if (cursor_q >= loaded_q) begin
          done_d  = 1'b1;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        hit_d  = 1'b0;
        iref_d = '0;
        if (pkey_q > rkey) begin
          // advance past the smaller inner key and fetch the next one
          cursor_d = cursor_nxt;
          raddr_o  = cursor_nxt[IDX_W-1:0];
          if (cursor_nxt >= loaded_q) begin
            done_d  = 1'b1;
            state_d = ST_EMIT;
          end
        end else begin
          if (pkey_q == rkey) begin
            hit_d  = 1'b1;
            iref_d = rdata_i[ENTRY_W-1:KEY_W];
            if (total_q != '1) begin
              total_d = total_q + TOTAL_W'(1);
            end
          end
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign res_o = '{
    matched:     hit_q,
    outer_ref:   pref_q,
    inner_ref:   iref_q,
    exhausted:   done_q,
    match_total: total_q
  };

endmodule

### hdl/sorted_merge_join_probe.sv
// Top level of the sort-merge equi-join probe: sequencer, inner store and output register.
// Start and load items are taken in the idle state; nothing is returned for them.
// A probe item runs through the issue, scan and emit states; the scan steps the cursor past
// smaller inner keys, one entry read per cycle, until entries run out (skipped once exhausted).
// The next item is accepted once the result sits in the output register.
// Reset (rst_ni low, asynchronous) clears the count, cursor, exhausted flag and match
// total; store contents are left as they are and need no clearing pass.
module sorted_merge_join_probe import smjp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // [31:0] join_key, [63:32] row_ref
  input  logic [1:0]   s_axis_tuser,  // [1:0] action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] outer_ref, [63:32] inner_ref, [64] exhausted, [96:65] match_total, rest zero
  output logic [103:0] m_axis_tdata,
  output logic [0:0]   m_axis_tuser   // [0] matched
);

  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [IDX_W-1:0]   raddr;
  logic [ENTRY_W-1:0] rdata;
  logic               res_valid;
  logic               res_ready;
  res_t               res;

  logic               out_valid_q, out_valid_d;
  res_t               out_res_q;

  smjp_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tuser),
    .key_i       (s_axis_tdata[31:0]),
    .ref_i       (s_axis_tdata[63:32]),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  smjp_ram #(
    .DEPTH (INNER_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.matched;
  assign m_axis_tdata  = {7'd0, out_res_q.match_total, out_res_q.exhausted,
                          out_res_q.inner_ref, out_res_q.outer_ref};

endmodule

### hdl/smjp_checker.sv
// Port-level checks of the join probe, bound to the top level.
module smjp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic [0:0]   m_axis_tuser
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_match_not_exh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tdata[64])
    else $error("match reported with exhausted set");

  a_nomatch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[63:32] == 32'd0)
    else $error("inner reference nonzero without match");

  a_match_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[96:65] != 32'd0)
    else $error("match with zero match total");

endmodule

bind sorted_merge_join_probe smjp_checker u_smjp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
